FILE: rtl/lru_buffer_list_defines.svh
// ----------------------------------------------------------------------------
// lru_buffer_list_defines
// Assertion macros shared by the LRU buffer list RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_BUFFER_LIST_DEFINES_SVH
`define LRU_BUFFER_LIST_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRUBL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LRUBL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lrubl_pkg.sv
// ----------------------------------------------------------------------------
// lrubl_pkg
// Shared types and constants for the LRU buffer list.
// ----------------------------------------------------------------------------
package lrubl_pkg;

  localparam int unsigned CNT_W       = 7;   // buffer_count and slot fields
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_RESET = 64;

  typedef enum logic [0:0] {
    OP_REBUILD = 1'b0,
    OP_TOUCH   = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_UNBUF   = 2'd1,
    ST_RANGE   = 2'd2,
    ST_CORRUPT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_CHECK,
    S_WR_SELF,
    S_WR_MOST,
    S_DONE
  } state_e;

endpackage

FILE: rtl/lru_buffer_list.sv
// ----------------------------------------------------------------------------
// lru_buffer_list
// LRU order over buffer slots 1..N kept as a doubly linked list in two RAMs.
//
// Input stream (s_axis): one beat is a command; tuser picks rebuild or touch,
// tdata carries the slot. Output stream (m_axis): one result beat per command
// with status and the most and least recently used slots (least is the victim).
// Config channel (cfg): writes buffer_count; write only while idle.
// Touch: from accept to result the block reads both links of the slot,
// then makes three writes, since the newer-link RAM takes up to three updates
// through its single write port. Link corruption and no-op touches end after
// the link read. Bad slot index, unbuffered touch and empty rebuild go
// straight to the result. Rebuild: one RAM entry per cycle from entry 0 to N.
// After reset the block sweeps all MAX_SLOTS+1 entries to build the initial
// chain and accepts no command meanwhile.
// One command is in flight at a time. A finished result sits in the
// output register; while the receiver stalls, the next command is still
// accepted and runs up to its result, which then waits for the register.
// ----------------------------------------------------------------------------
`include "lru_buffer_list_defines.svh"

module lru_buffer_list
  import lrubl_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i,     // buffer_count
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [6:0] slot_index
  input  logic [0:0]       s_axis_tuser,   // [0] opcode
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata    // [1:0] status, [8:2] most, [15:9] least
);

  localparam int unsigned DEPTH  = MAX_SLOTS + 1;
  localparam int unsigned SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMP_W  = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;
  localparam int unsigned RESET_N_I =
    (COUNT_RESET > MAX_SLOTS) ? MAX_SLOTS : COUNT_RESET;
  localparam logic [SLOT_W-1:0] RESET_N   = SLOT_W'(RESET_N_I);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_SLOTS);

  // Registers
  state_e            state_d, state_q;
  logic [CNT_W-1:0]  count_q;
  logic [SLOT_W-1:0] most_d, most_q, least_d, least_q;
  logic [SLOT_W-1:0] n_d, n_q;
  logic [SLOT_W-1:0] slot_d, slot_q;
  logic [SLOT_W-1:0] cnt_d, cnt_q;
  logic [SLOT_W-1:0] end_d, end_q;
  logic              boot_d, boot_q;
  status_e           status_d, status_q;
  logic              out_valid_d, out_valid_q;
  logic [15:0]       out_data_q;

  // Input decode
  opcode_e          in_op;
  logic [CNT_W-1:0] in_slot;
  logic             in_acc;
  logic             out_load;
  logic [CMP_W-1:0] eff_x, slot_x, cnt_x, n_x, nw_x, od_x;
  logic [SLOT_W-1:0] eff_n;

  // RAM ports
  logic              nw_we, od_we;
  logic [SLOT_W-1:0] nw_waddr, od_waddr, nw_wdata, od_wdata;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] nw_rdata, od_rdata;

  logic [CMP_W-1:0] most_x, least_x;

  assign in_op   = opcode_e'(s_axis_tuser);
  assign in_slot = s_axis_tdata[CNT_W-1:0];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  // Effective count: buffer_count saturated to MAX_SLOTS
  assign eff_x  = (CMP_W'(count_q) > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS)
                                                        : CMP_W'(count_q);
  assign eff_n  = eff_x[SLOT_W-1:0];
  assign slot_x = CMP_W'(in_slot);
  assign cnt_x  = CMP_W'(cnt_q);
  assign n_x    = CMP_W'(n_q);
  assign nw_x   = CMP_W'(nw_rdata);
  assign od_x   = CMP_W'(od_rdata);

  assign rd_en   = in_acc;
  assign rd_addr = slot_x[SLOT_W-1:0];

  lrubl_ram #(.DEPTH(DEPTH), .ADDR_W(SLOT_W), .DATA_W(SLOT_W)) u_newer_ram (
    .clk_i   (clk_i),
    .we_i    (nw_we),
    .waddr_i (nw_waddr),
    .wdata_i (nw_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (nw_rdata)
  );

  lrubl_ram #(.DEPTH(DEPTH), .ADDR_W(SLOT_W), .DATA_W(SLOT_W)) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (od_we),
    .waddr_i (od_waddr),
    .wdata_i (od_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (od_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_SWEEP: begin
        if (cnt_q == end_q) begin
          state_d = boot_q ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == OP_REBUILD) begin
            state_d = (eff_n == '0) ? S_DONE : S_SWEEP;
          end else if (eff_n == '0 || slot_x == '0 || slot_x > eff_x) begin
            state_d = S_DONE;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (nw_x > n_x || od_x > n_x || nw_rdata == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_WR_SELF;
        end
      end
      S_WR_SELF: state_d = S_WR_MOST;
      S_WR_MOST: state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM writes
  always_comb begin
    most_d   = most_q;
    least_d  = least_q;
    n_d      = n_q;
    slot_d   = slot_q;
    cnt_d    = cnt_q;
    end_d    = end_q;
    boot_d   = boot_q;
    status_d = status_q;
    nw_we    = 1'b0;
    od_we    = 1'b0;
    nw_waddr = cnt_q;
    od_waddr = cnt_q;
    nw_wdata = '0;
    od_wdata = '0;
    case (state_q)
      S_SWEEP: begin
        // Chain 1..n; entry 0 and entries above n get no link
        nw_we = 1'b1;
        od_we = 1'b1;
        if (cnt_x >= CMP_W'(1) && cnt_x < n_x) begin
          nw_wdata = cnt_q + SLOT_W'(1);
        end
        if (cnt_x >= CMP_W'(2) && cnt_x <= n_x) begin
          od_wdata = cnt_q - SLOT_W'(1);
        end
        cnt_d = cnt_q + SLOT_W'(cnt_q != end_q);
        if (cnt_q == end_q) begin
          boot_d = 1'b0;
          if (!boot_q) begin
            most_d   = n_q;
            least_d  = SLOT_W'(1);
            status_d = ST_OK;
          end
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          n_d    = eff_n;
          slot_d = slot_x[SLOT_W-1:0];
          cnt_d  = '0;
          end_d  = eff_n;
          status_d = ST_OK;
          if (in_op == OP_REBUILD) begin
            most_d  = '0;
            least_d = '0;
          end else if (eff_n == '0) begin
            status_d = ST_UNBUF;
          end else if (slot_x == '0 || slot_x > eff_x) begin
            status_d = ST_RANGE;
          end
        end
      end
      S_CHECK: begin
        if (nw_x > n_x || od_x > n_x) begin
          status_d = ST_CORRUPT;
        end else if (nw_rdata != '0) begin
          // Unlink: older[nw] = od, newer[od] = nw or move the least end
          od_we    = 1'b1;
          od_waddr = nw_rdata;
          od_wdata = od_rdata;
          if (od_rdata != '0) begin
            nw_we    = 1'b1;
            nw_waddr = od_rdata;
            nw_wdata = nw_rdata;
          end else begin
            least_d = nw_rdata;
          end
        end
      end
      S_WR_SELF: begin
        nw_we    = 1'b1;
        nw_waddr = slot_q;
        nw_wdata = '0;
        od_we    = 1'b1;
        od_waddr = slot_q;
        od_wdata = most_q;
      end
      S_WR_MOST: begin
        // Stale zero pointer lands on the unused entry 0
        nw_we    = 1'b1;
        nw_waddr = most_q;
        nw_wdata = slot_q;
        most_d   = slot_q;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign most_x  = CMP_W'(most_q);
  assign least_x = CMP_W'(least_q);

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      count_q     <= CNT_W'(COUNT_RESET);
      most_q      <= RESET_N;
      least_q     <= SLOT_W'(1);
      n_q         <= RESET_N;
      cnt_q       <= '0;
      end_q       <= LAST_SLOT;
      boot_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      most_q      <= most_d;
      least_q     <= least_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      end_q       <= end_d;
      boot_q      <= boot_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    status_q <= status_d;
    if (out_load) begin
      out_data_q <= {least_x[CNT_W-1:0], most_x[CNT_W-1:0], status_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `LRUBL_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_acc,
    state_q != S_IDLE, "command accepted but control stayed idle")
  `LRUBL_ASSERT_NOW(a_check_slot_in_range, clk_i, rst_ni, state_q == S_CHECK,
    slot_q != '0 && slot_q <= n_q, "link check on a slot outside 1..N")
  `LRUBL_ASSERT_NOW(a_sweep_bound, clk_i, rst_ni, state_q == S_SWEEP,
    cnt_q <= end_q && end_q <= LAST_SLOT, "sweep counter past its end")
  `LRUBL_ASSERT_NOW(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q),
    $past(state_q) == S_DONE, "result beat raised outside the done step")

endmodule

FILE: rtl/lrubl_ram.sv
// ----------------------------------------------------------------------------
// lrubl_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lrubl_ram #(
  parameter int unsigned DEPTH  = 65,
  parameter int unsigned ADDR_W = 7,
  parameter int unsigned DATA_W = 7
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
